### hw/rtl/rps_pkg.sv
`default_nettype none
package rps_pkg;

  // Fixed field widths of the coefficient and result channels.
  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int POWER_W     = 2 * DIFF_W;
  localparam int SUM_W       = 64;
  localparam int COUNT_W     = 40;
  localparam int MEAN_W      = 34;
  localparam int READ_BIN_W  = 7;
  localparam int BIN_W       = 8;
  localparam int OPCODE_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBTRACT  = 2'd2;

  // Register values after reset.
  localparam logic [7:0] BIN_COUNT_RESET = 8'd65;
  localparam logic [8:0] ROW_COUNT_RESET = 9'd128;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // One job handed from the front end to the bin store.
  typedef struct packed {
    op_t                op;
    logic               in_range;
    logic [BIN_W-1:0]   bin;
    logic [POWER_W-1:0] power;
  } job_t;

endpackage
`default_nettype wire

### hw/rtl/rps_ifs.sv
`default_nettype none
interface rps_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [rps_pkg::OPCODE_W-1:0]             opcode;
  logic signed [rps_pkg::SAMPLE_BITS-1:0]   coef_re;
  logic signed [rps_pkg::SAMPLE_BITS-1:0]   coef_im;
  logic signed [rps_pkg::SAMPLE_BITS-1:0]   sig_re;
  logic signed [rps_pkg::SAMPLE_BITS-1:0]   sig_im;
  logic [rps_pkg::READ_BIN_W-1:0]           read_bin;
  modport source (output valid, opcode, coef_re, coef_im, sig_re, sig_im, read_bin,
                  input ready);
  modport sink (input valid, opcode, coef_re, coef_im, sig_re, sig_im, read_bin,
                output ready);
endinterface

interface rps_out_if;
  logic                             valid;
  logic                             ready;
  logic [rps_pkg::READ_BIN_W-1:0]   bin_index;
  logic [rps_pkg::MEAN_W-1:0]       mean_power;
  logic [rps_pkg::COUNT_W-1:0]      sample_total;
  modport source (output valid, bin_index, mean_power, sample_total, input ready);
  modport sink (input valid, bin_index, mean_power, sample_total, output ready);
endinterface

interface rps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rps_pkg::CFG_INDEX_W-1:0]   index;
  logic [rps_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/rps_front.sv
`default_nettype none
module rps_front #(
  parameter int MAX_BINS = 128,
  parameter int MAX_ROWS = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  rps_in_if.sink              req,
  rps_cfg_if.sink             cfg,
  input  wire logic           init_done,
  input  wire logic           q_full,
  output logic                q_push,
  output rps_pkg::job_t       q_job
);

  localparam int XW = $clog2(MAX_BINS);
  localparam int YW = $clog2(MAX_ROWS);
  localparam int WW = $clog2(MAX_BINS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int CW = (XW > YW) ? XW : YW;
  localparam int DW = 2 * CW + 1;
  localparam int RW = CW + 1;

  typedef struct packed {
    rps_pkg::op_t                   op;
    logic [rps_pkg::POWER_W-1:0]    power;
    logic [rps_pkg::READ_BIN_W-1:0] read_bin;
    logic [WW-1:0]                  w;
  } pay_t;

  logic [7:0] bin_count;
  logic [8:0] row_count;
  logic       subtract_signal;

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [XW-1:0] col_next;
  logic [YW-1:0] row_next;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [XW-1:0] x_cur;
  logic [YW-1:0] y_cur;
  logic [YW-1:0] y_abs;
  logic          op_known;
  logic          accept;
  logic          en;

  logic signed [rps_pkg::DIFF_W-1:0] re_diff;
  logic signed [rps_pkg::DIFF_W-1:0] im_diff;

  logic                              s1_valid;
  rps_pkg::op_t                      s1_op;
  logic [XW-1:0]                     s1_x;
  logic [YW-1:0]                     s1_y;
  logic signed [rps_pkg::DIFF_W-1:0] s1_re;
  logic signed [rps_pkg::DIFF_W-1:0] s1_im;
  logic [rps_pkg::READ_BIN_W-1:0]    s1_bin;
  logic [WW-1:0]                     s1_w;

  logic                              s2_valid;
  rps_pkg::op_t                      s2_op;
  logic [2*XW-1:0]                   s2_xx;
  logic [2*YW-1:0]                   s2_yy;
  logic [rps_pkg::POWER_W-1:0]       s2_rr;
  logic [rps_pkg::POWER_W-1:0]       s2_ii;
  logic [rps_pkg::READ_BIN_W-1:0]    s2_bin;
  logic [WW-1:0]                     s2_w;

  logic          p_valid [RW+1];
  logic [DW-1:0] p_rem   [RW+1];
  logic [RW-1:0] p_root  [RW+1];
  pay_t          p_pay   [RW+1];

  logic tail_wants;

  // The whole front pipeline holds while the queue is full.
  assign en       = !q_full;
  assign req.ready = en && init_done;
  assign accept   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign op_known = (req.opcode == rps_pkg::OP_ACC) || (req.opcode == rps_pkg::OP_READ) ||
                    (req.opcode == rps_pkg::OP_CLEAR);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count       <= rps_pkg::BIN_COUNT_RESET;
      row_count       <= rps_pkg::ROW_COUNT_RESET;
      subtract_signal <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        rps_pkg::REG_BIN_COUNT: bin_count       <= cfg.data[7:0];
        rps_pkg::REG_ROW_COUNT: row_count       <= cfg.data;
        rps_pkg::REG_SUBTRACT:  subtract_signal <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Raster size limited to the supported range.
  always_comb begin
    if (bin_count < 8'd2) begin
      w_eff = WW'(2);
    end else if (int'(bin_count) > MAX_BINS) begin
      w_eff = WW'(MAX_BINS);
    end else begin
      w_eff = WW'(bin_count);
    end
    if (row_count < 9'd2) begin
      h_eff = HW'(2);
    end else if (int'(row_count) > MAX_ROWS) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(row_count);
    end
  end

  // Current position, row folding and the next raster position.
  always_comb begin
    x_cur = (int'(col) < int'(w_eff)) ? col : '0;
    y_cur = (int'(row) < int'(h_eff)) ? row : '0;
    if (int'(y_cur) < int'(w_eff)) begin
      y_abs = y_cur;
    end else begin
      y_abs = YW'(h_eff - HW'(y_cur));
    end
    if (int'(x_cur) + 1 >= int'(w_eff)) begin
      col_next = '0;
      if (int'(y_cur) + 1 >= int'(h_eff)) begin
        row_next = '0;
      end else begin
        row_next = y_cur + 1'b1;
      end
    end else begin
      col_next = x_cur + 1'b1;
      row_next = y_cur;
    end
  end

  // Coefficient, minus the signal in subtract mode.
  always_comb begin
    re_diff = rps_pkg::DIFF_W'(req.coef_re);
    im_diff = rps_pkg::DIFF_W'(req.coef_im);
    if (subtract_signal) begin
      re_diff = re_diff - rps_pkg::DIFF_W'(req.sig_re);
      im_diff = im_diff - rps_pkg::DIFF_W'(req.sig_im);
    end
  end

  // Position tracking on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (req.opcode == rps_pkg::OP_ACC) begin
        col <= col_next;
        row <= row_next;
      end else if (req.opcode == rps_pkg::OP_CLEAR) begin
        col <= '0;
        row <= '0;
      end
    end
  end

  // Stage 1: classified item; the unused opcode is dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && op_known;
    end
    if (en) begin
      s1_op  <= rps_pkg::op_t'(req.opcode);
      s1_x   <= x_cur;
      s1_y   <= y_abs;
      s1_re  <= re_diff;
      s1_im  <= im_diff;
      s1_bin <= req.read_bin;
      s1_w   <= w_eff;
    end
  end

  // Stage 2: squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_op  <= s1_op;
      s2_xx  <= s1_x * s1_x;
      s2_yy  <= s1_y * s1_y;
      s2_rr  <= s1_re * s1_re;
      s2_ii  <= s1_im * s1_im;
      s2_bin <= s1_bin;
      s2_w   <= s1_w;
    end
  end

  // Stage 3: squared radius and power; this is the root pipeline input.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid[0] <= 1'b0;
    end else if (en) begin
      p_valid[0] <= s2_valid;
    end
    if (en) begin
      p_rem[0]           <= DW'(s2_xx) + DW'(s2_yy);
      p_root[0]          <= '0;
      p_pay[0].op        <= s2_op;
      p_pay[0].power     <= s2_rr + s2_ii;
      p_pay[0].read_bin  <= s2_bin;
      p_pay[0].w         <= s2_w;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar i = 0; i < RW; i++) begin : g_root
    localparam int K = RW - 1 - i;
    logic [DW-1:0] trial;
    logic          fits;

    assign trial = (DW'(p_root[i]) << (K + 1)) + (DW'(1) << (2 * K));
    assign fits  = (p_rem[i] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        p_valid[i+1] <= 1'b0;
      end else if (en) begin
        p_valid[i+1] <= p_valid[i];
      end
      if (en) begin
        p_pay[i+1] <= p_pay[i];
        if (fits) begin
          p_rem[i+1]  <= p_rem[i] - trial;
          p_root[i+1] <= p_root[i] | (RW'(1) << K);
        end else begin
          p_rem[i+1]  <= p_rem[i];
          p_root[i+1] <= p_root[i];
        end
      end
    end
  end

  // Tail: skip coefficients beyond the last bin, hand the rest on.
  assign tail_wants = (p_pay[RW].op != rps_pkg::OP_ACC) ||
                      (int'(p_root[RW]) < int'(p_pay[RW].w));
  assign q_push     = en && p_valid[RW] && tail_wants;

  always_comb begin
    q_job.op    = p_pay[RW].op;
    q_job.power = p_pay[RW].power;
    if (p_pay[RW].op == rps_pkg::OP_ACC) begin
      q_job.bin      = rps_pkg::BIN_W'(p_root[RW]);
      q_job.in_range = 1'b1;
    end else begin
      q_job.bin      = rps_pkg::BIN_W'(p_pay[RW].read_bin);
      q_job.in_range = (int'(p_pay[RW].read_bin) < MAX_BINS);
    end
  end

  logic unused_rem;
  assign unused_rem = ^p_rem[RW];

endmodule
`default_nettype wire

### hw/rtl/rps_queue.sv
`default_nettype none
module rps_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rps_pkg::job_t  push_job,
  output logic                full,
  output logic                pop_valid,
  output rps_pkg::job_t       pop_job,
  input  wire logic           pop
);

  rps_pkg::job_t                  slots [rps_pkg::QUEUE_DEPTH];
  logic [rps_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [rps_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [rps_pkg::QUEUE_PTR_W:0]   fill;

  assign full      = (int'(fill) == rps_pkg::QUEUE_DEPTH);
  assign pop_valid = (fill != '0);
  assign pop_job   = slots[rd_ptr];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rps_back.sv
`default_nettype none
module rps_back #(
  parameter int MAX_BINS = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire rps_pkg::job_t  q_job,
  output logic                q_pop,
  output logic                init_done,
  rps_out_if.source           rsp
);

  localparam int BW = $clog2(MAX_BINS);
  localparam int SW = $clog2(rps_pkg::SUM_W);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_DIV_RD,
    ST_DIV_LD,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state;
  rps_pkg::job_t job;
  logic [BW-1:0] clr_addr;
  logic [SW-1:0] step;

  logic [rps_pkg::SUM_W-1:0]   sums   [MAX_BINS];
  logic [rps_pkg::COUNT_W-1:0] counts [MAX_BINS];
  logic [rps_pkg::SUM_W-1:0]   rd_sum;
  logic [rps_pkg::COUNT_W-1:0] rd_cnt;

  logic                        mem_we;
  logic [BW-1:0]               mem_addr;
  logic [rps_pkg::SUM_W-1:0]   wr_sum;
  logic [rps_pkg::COUNT_W-1:0] wr_cnt;
  logic [rps_pkg::SUM_W:0]     sum_ext;

  logic [rps_pkg::SUM_W-1:0]   quot;
  logic [rps_pkg::COUNT_W-1:0] rem;
  logic [rps_pkg::COUNT_W-1:0] divisor;
  logic [rps_pkg::COUNT_W:0]   trial;
  logic [rps_pkg::COUNT_W:0]   trial_sub;

  assign q_pop  = (state == ST_IDLE) && q_valid;

  // Saturating update of the addressed bin.
  assign sum_ext = {1'b0, rd_sum} + (rps_pkg::SUM_W + 1)'(job.power);

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = BW'(job.bin);
    wr_sum   = '0;
    wr_cnt   = '0;
    if (state == ST_CLR) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
    end else if (state == ST_ACC_WR) begin
      mem_we = 1'b1;
      wr_sum = sum_ext[rps_pkg::SUM_W] ? '1 : sum_ext[rps_pkg::SUM_W-1:0];
      wr_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + 1'b1;
    end
  end

  // Bin store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums[mem_addr]   <= wr_sum;
      counts[mem_addr] <= wr_cnt;
    end
    rd_sum <= sums[mem_addr];
    rd_cnt <= counts[mem_addr];
  end

  // One restoring divide step.
  assign trial     = {rem, quot[rps_pkg::SUM_W-1]};
  assign trial_sub = trial - {1'b0, divisor};

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      init_done <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLR: begin
          if (int'(clr_addr) == MAX_BINS - 1) begin
            state     <= ST_IDLE;
            init_done <= 1'b1;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            job <= q_job;
            unique case (q_job.op)
              rps_pkg::OP_ACC:   state <= ST_ACC_RD;
              rps_pkg::OP_READ: begin
                if (q_job.in_range) begin
                  state <= ST_DIV_RD;
                end else begin
                  rsp.bin_index    <= q_job.bin[rps_pkg::READ_BIN_W-1:0];
                  rsp.mean_power   <= '0;
                  rsp.sample_total <= '0;
                  rsp.valid        <= 1'b1;
                  state            <= ST_OUT;
                end
              end
              rps_pkg::OP_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLR;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_ACC_RD: state <= ST_ACC_WR;
        ST_ACC_WR: state <= ST_IDLE;
        ST_DIV_RD: state <= ST_DIV_LD;
        ST_DIV_LD: begin
          quot             <= rd_sum;
          rem              <= '0;
          divisor          <= rd_cnt;
          step             <= '0;
          rsp.bin_index    <= job.bin[rps_pkg::READ_BIN_W-1:0];
          rsp.sample_total <= rd_cnt;
          if (rd_cnt == '0) begin
            rsp.mean_power <= '0;
            rsp.valid      <= 1'b1;
            state          <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!trial_sub[rps_pkg::COUNT_W]) begin
            rem  <= trial_sub[rps_pkg::COUNT_W-1:0];
            quot <= {quot[rps_pkg::SUM_W-2:0], 1'b1};
          end else begin
            rem  <= trial[rps_pkg::COUNT_W-1:0];
            quot <= {quot[rps_pkg::SUM_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (&step) begin
            state <= ST_OUT;
            rsp.valid <= 1'b1;
            if (!trial_sub[rps_pkg::COUNT_W]) begin
              rsp.mean_power <= (|quot[rps_pkg::SUM_W-2:rps_pkg::MEAN_W-1]) ? '1 :
                                {quot[rps_pkg::MEAN_W-2:0], 1'b1};
            end else begin
              rsp.mean_power <= (|quot[rps_pkg::SUM_W-2:rps_pkg::MEAN_W-1]) ? '1 :
                                {quot[rps_pkg::MEAN_W-2:0], 1'b0};
            end
          end
        end
        ST_OUT: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/radial_power_spectrum_unit.sv
// Channel   Dir  Transfer            Payload
// req       in   valid & ready       opcode, coef_re, coef_im, sig_re, sig_im, read_bin
// rsp       out  valid & ready       bin_index, mean_power, sample_total
// cfg       in   valid & ready       index, data (always ready)
//
// The front end takes one item per cycle while the queue is not full and computes the
// bin in a pipeline of clog2 stages plus four; a four-entry queue separates it from
// the bin store. The bin store reads, updates and writes each accumulated coefficient
// on its single memory port, runs a 64-step divider per read, and clears one bin per
// cycle. Reset is synchronous; after it the store is swept, and req is not ready until
// the sweep is done. A stalled rsp holds its result and backs up the queue.
`default_nettype none
module radial_power_spectrum_unit #(
  parameter int MAX_BINS = 128,
  parameter int MAX_ROWS = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  rps_in_if.sink    req,
  rps_out_if.source rsp,
  rps_cfg_if.sink   cfg
);

  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          init_done;
  rps_pkg::job_t push_job;
  rps_pkg::job_t pop_job;

  // Front end: configuration, position and bin computation.
  rps_front #(
    .MAX_BINS(MAX_BINS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Job queue between the two sides.
  rps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (pop_job),
    .pop       (q_pop)
  );

  // Bin store, divider and result register.
  rps_back #(
    .MAX_BINS(MAX_BINS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .init_done (init_done),
    .rsp       (rsp)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue written while full");

  a_ready_after_sweep: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> init_done) else $error("input ready before store sweep finished");

  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.sample_total == '0) |-> rsp.mean_power == '0)
    else $error("empty bin reports nonzero power");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue read while empty");
`endif

endmodule
`default_nettype wire
